@@ rtl/fft_magnitude_spectrum_assert.svh @@
// ----------------------------------------------------------------------------
// fft magnitude spectrum assertion macros
// clocked on i_clk, off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef FFT_MAGNITUDE_SPECTRUM_ASSERT_SVH
`define FFT_MAGNITUDE_SPECTRUM_ASSERT_SVH

// consequent in the same cycle
`define FMS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fms check failed");

// consequent in the next cycle
`define FMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fms check failed");

`endif

@@ rtl/fms_pkg.sv @@
// ----------------------------------------------------------------------------
// fms_pkg
// types, codes and twiddle table shared by the spectrum block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fms_pkg;

    localparam int STORE_DEPTH = 128;
    localparam int ADDR_W      = 7;

    // write data select
    localparam logic [2:0] WS_SAMPLE = 3'd0;
    localparam logic [2:0] WS_ZERO   = 3'd1;
    localparam logic [2:0] WS_E      = 3'd2;
    localparam logic [2:0] WS_O      = 3'd3;
    localparam logic [2:0] WS_SUM    = 3'd4;
    localparam logic [2:0] WS_DIF    = 3'd5;

    // multiplier operand select
    localparam logic [2:0] MUL_WR_OR = 3'd0;
    localparam logic [2:0] MUL_WI_OI = 3'd1;
    localparam logic [2:0] MUL_WR_OI = 3'd2;
    localparam logic [2:0] MUL_WI_OR = 3'd3;
    localparam logic [2:0] MUL_RE_RE = 3'd4;
    localparam logic [2:0] MUL_IM_IM = 3'd5;

    // accumulator operation
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;
    localparam logic [1:0] ACC_SUB  = 2'd3;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [2:0]        wsel;
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              ld_e;
        logic              ld_o;
        logic              ld_tw;
        logic [5:0]        tw_idx;
        logic [2:0]        mul_sel;
        logic [1:0]        acc_op;
        logic              ld_tr;
        logic              ld_ti;
        logic              mag_start;
        logic [7:0]        n_count;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] wr;
        logic signed [15:0] wi;
    } t_tw;

    localparam logic [15:0] QCOS [0:32] = '{
        16'd32767, 16'd32729, 16'd32610, 16'd32413, 16'd32138, 16'd31786,
        16'd31357, 16'd30853, 16'd30274, 16'd29622, 16'd28899, 16'd28106,
        16'd27246, 16'd26320, 16'd25330, 16'd24279, 16'd23170, 16'd22006,
        16'd20788, 16'd19520, 16'd18205, 16'd16846, 16'd15447, 16'd14010,
        16'd12540, 16'd11039, 16'd9512,  16'd7962,  16'd6393,  16'd4808,
        16'd3212,  16'd1608,  16'd0
    };

    function automatic t_tw twiddle(input logic [5:0] m);
        t_tw                t;
        logic signed [15:0] c;
        logic signed [15:0] s;
        if (m <= 6'd32) begin
            c = signed'(QCOS[m]);
            s = signed'(QCOS[6'(6'd32 - m)]);
        end else begin
            c = -signed'(QCOS[6'(7'd64 - {1'b0, m})]);
            s = signed'(QCOS[6'(m - 6'd32)]);
        end
        t.wr = c;
        t.wi = -s;
        return t;
    endfunction

endpackage

@@ rtl/fms_ram.sv @@
// ----------------------------------------------------------------------------
// fms_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fms_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fms_ctrl.sv @@
// ----------------------------------------------------------------------------
// fms_ctrl
// sequencer for load, padding, reordering, butterflies and bin output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fms_ctrl import fms_pkg::*; #(
    parameter int MAX_POINTS = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_frame_end,
    input  logic       i_mag_done,
    output logic       o_busy,
    output t_cmd       o_cmd,
    output logic       o_strobe,
    output logic [5:0] o_bin_index,
    output logic       o_bin_last
);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_REV  = 3'd2;
    localparam logic [2:0] S_BFLY = 3'd3;
    localparam logic [2:0] S_MAG  = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;

    localparam logic [7:0] LIMIT = 8'(MAX_POINTS);

    logic [2:0] r_state, n_state;
    logic [7:0] r_count, n_count;
    logic [7:0] r_n, n_n;
    logic [2:0] r_lvl, n_lvl;
    logic [7:0] r_i, n_i;
    logic [2:0] r_stg, n_stg;
    logic [3:0] r_step, n_step;
    logic       r_strobe, n_strobe;
    logic [5:0] r_bin, n_bin;
    logic       r_last, n_last;

    logic [7:0] p;
    logic [7:0] hp;
    logic [7:0] cnt_new;
    logic [6:0] rv;
    logic [6:0] half;
    logic [6:0] a_addr;
    logic [6:0] o_addr;
    logic [6:0] tw_full;

    function automatic logic [2:0] clog(input logic [7:0] n);
        logic [2:0] l;
        l = 3'd7;
        for (int k = 7; k >= 0; k--) begin
            if ((9'd1 << k) >= {1'b0, n}) begin
                l = 3'(k);
            end
        end
        return l;
    endfunction

    function automatic logic [6:0] rev7(input logic [6:0] x);
        logic [6:0] y;
        for (int k = 0; k < 7; k++) begin
            y[6-k] = x[k];
        end
        return y;
    endfunction

    assign p       = 8'd1 << r_lvl;
    assign hp      = p >> 1;
    assign cnt_new = (r_count < LIMIT) ? r_count + 8'd1 : r_count;
    assign rv      = rev7(r_i[6:0]) >> (3'd7 - r_lvl);
    assign half    = 7'd1 << (r_stg - 3'd1);
    assign a_addr  = ((r_i[6:0] >> (r_stg - 3'd1)) << r_stg) | (r_i[6:0] & (half - 7'd1));
    assign o_addr  = a_addr | half;
    assign tw_full = (r_i[6:0] & (half - 7'd1)) << (3'd7 - r_stg);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_n      = r_n;
        n_lvl    = r_lvl;
        n_i      = r_i;
        n_stg    = r_stg;
        n_step   = r_step;
        n_strobe = 1'b0;
        n_bin    = r_bin;
        n_last   = r_last;
        o_cmd         = '0;
        o_cmd.n_count = r_n;
        unique case (r_state)
            S_LOAD: begin
                if (i_start) begin
                    if (r_count < LIMIT) begin
                        o_cmd.we    = 1'b1;
                        o_cmd.waddr = r_count[6:0];
                        o_cmd.wsel  = WS_SAMPLE;
                    end
                    if (i_frame_end) begin
                        n_count = 8'd0;
                        if (cnt_new > 8'd1) begin
                            n_n     = cnt_new;
                            n_lvl   = clog(cnt_new);
                            n_i     = cnt_new;
                            n_state = S_PAD;
                        end
                    end else begin
                        n_count = cnt_new;
                    end
                end
            end
            S_PAD: begin
                if (r_i < p) begin
                    o_cmd.we    = 1'b1;
                    o_cmd.waddr = r_i[6:0];
                    o_cmd.wsel  = WS_ZERO;
                    n_i         = r_i + 8'd1;
                end else begin
                    n_i     = 8'd0;
                    n_step  = 4'd0;
                    n_state = S_REV;
                end
            end
            S_REV: begin
                case (r_step)
                    4'd0: begin
                        if (r_i >= p) begin
                            n_i     = 8'd0;
                            n_stg   = 3'd1;
                            n_state = S_BFLY;
                        end else if (rv > r_i[6:0]) begin
                            o_cmd.re    = 1'b1;
                            o_cmd.raddr = r_i[6:0];
                            n_step      = 4'd1;
                        end else begin
                            n_i = r_i + 8'd1;
                        end
                    end
                    4'd1: begin
                        o_cmd.re    = 1'b1;
                        o_cmd.raddr = rv;
                        o_cmd.ld_e  = 1'b1;
                        n_step      = 4'd2;
                    end
                    4'd2: begin
                        o_cmd.ld_o = 1'b1;
                        n_step     = 4'd3;
                    end
                    4'd3: begin
                        o_cmd.we    = 1'b1;
                        o_cmd.waddr = r_i[6:0];
                        o_cmd.wsel  = WS_O;
                        n_step      = 4'd4;
                    end
                    default: begin
                        o_cmd.we    = 1'b1;
                        o_cmd.waddr = rv;
                        o_cmd.wsel  = WS_E;
                        n_step      = 4'd0;
                        n_i         = r_i + 8'd1;
                    end
                endcase
            end
            S_BFLY: begin
                n_step = r_step + 4'd1;
                case (r_step)
                    4'd0: begin
                        o_cmd.re     = 1'b1;
                        o_cmd.raddr  = a_addr;
                        o_cmd.ld_tw  = 1'b1;
                        o_cmd.tw_idx = tw_full[5:0];
                    end
                    4'd1: begin
                        o_cmd.re    = 1'b1;
                        o_cmd.raddr = o_addr;
                        o_cmd.ld_e  = 1'b1;
                    end
                    4'd2: o_cmd.ld_o = 1'b1;
                    4'd3: o_cmd.mul_sel = MUL_WR_OR;
                    4'd4: begin
                        o_cmd.acc_op  = ACC_LOAD;
                        o_cmd.mul_sel = MUL_WI_OI;
                    end
                    4'd5: begin
                        o_cmd.acc_op  = ACC_SUB;
                        o_cmd.mul_sel = MUL_WR_OI;
                    end
                    4'd6: begin
                        o_cmd.ld_tr   = 1'b1;
                        o_cmd.acc_op  = ACC_LOAD;
                        o_cmd.mul_sel = MUL_WI_OR;
                    end
                    4'd7: o_cmd.acc_op = ACC_ADD;
                    4'd8: o_cmd.ld_ti = 1'b1;
                    4'd9: begin
                        o_cmd.we    = 1'b1;
                        o_cmd.waddr = a_addr;
                        o_cmd.wsel  = WS_SUM;
                    end
                    default: begin
                        o_cmd.we    = 1'b1;
                        o_cmd.waddr = o_addr;
                        o_cmd.wsel  = WS_DIF;
                        n_step      = 4'd0;
                        if (r_i + 8'd1 == hp) begin
                            n_i = 8'd0;
                            if (r_stg == r_lvl) begin
                                n_state = S_MAG;
                            end else begin
                                n_stg = r_stg + 3'd1;
                            end
                        end else begin
                            n_i = r_i + 8'd1;
                        end
                    end
                endcase
            end
            S_MAG: begin
                n_step = r_step + 4'd1;
                case (r_step)
                    4'd0: begin
                        o_cmd.re    = 1'b1;
                        o_cmd.raddr = r_i[6:0];
                    end
                    4'd1: o_cmd.ld_e = 1'b1;
                    4'd2: o_cmd.mul_sel = MUL_RE_RE;
                    4'd3: begin
                        o_cmd.acc_op  = ACC_LOAD;
                        o_cmd.mul_sel = MUL_IM_IM;
                    end
                    4'd4: o_cmd.acc_op = ACC_ADD;
                    default: begin
                        o_cmd.mag_start = 1'b1;
                        n_step          = 4'd0;
                        n_state         = S_WAIT;
                    end
                endcase
            end
            S_WAIT: begin
                if (i_mag_done) begin
                    n_strobe = 1'b1;
                    n_bin    = r_i[5:0];
                    n_last   = (r_i + 8'd1 == hp);
                    if (r_i + 8'd1 == hp) begin
                        n_state = S_LOAD;
                    end else begin
                        n_i     = r_i + 8'd1;
                        n_state = S_MAG;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= 8'd0;
            r_strobe <= 1'b0;
            r_step   <= 4'd0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            r_step   <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_lvl  <= n_lvl;
        r_i    <= n_i;
        r_stg  <= n_stg;
        r_bin  <= n_bin;
        r_last <= n_last;
    end

    assign o_busy      = (r_state != S_LOAD);
    assign o_strobe    = r_strobe;
    assign o_bin_index = r_bin;
    assign o_bin_last  = r_last;

endmodule

@@ rtl/fms_dpath.sv @@
// ----------------------------------------------------------------------------
// fms_dpath
// sample store, shared butterfly multiplier and magnitude root/divide unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fms_dpath import fms_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic signed [15:0] i_sample,
    output logic               o_mag_done,
    output logic [15:0]        o_magnitude
);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_SQRT = 2'd1;
    localparam logic [1:0] M_DIV  = 2'd2;

    logic [63:0]        wdata;
    logic [63:0]        rdata;
    logic signed [31:0] r_er, r_ei, r_or, r_oi;
    logic signed [15:0] r_wr, r_wi;
    logic signed [31:0] op_a, op_b;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic signed [63:0] rsum;
    logic signed [63:0] rnd;
    logic signed [31:0] r_tr, r_ti;
    t_tw                tw;

    logic [1:0]  r_mph;
    logic [4:0]  r_cnt;
    logic [49:0] r_rad;
    logic [27:0] r_rem;
    logic [24:0] r_root;
    logic [25:0] r_num;
    logic [8:0]  r_dr;
    logic [8:0]  r_den;
    logic        r_done;
    logic [15:0] r_mag;

    logic [27:0] rem_sh;
    logic [27:0] trial;
    logic        sq_bit;
    logic [24:0] root_nx;
    logic [9:0]  dr_sh;
    logic        dv_bit;
    logic [25:0] quo_nx;

    fms_ram #(
        .WIDTH (64),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.we),
        .i_waddr (i_cmd.waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.re),
        .i_raddr (i_cmd.raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        case (i_cmd.wsel)
            WS_SAMPLE: wdata = {{16{i_sample[15]}}, i_sample, 32'd0};
            WS_E:      wdata = {r_er, r_ei};
            WS_O:      wdata = {r_or, r_oi};
            WS_SUM:    wdata = {r_er + r_tr, r_ei + r_ti};
            WS_DIF:    wdata = {r_er - r_tr, r_ei - r_ti};
            default:   wdata = 64'd0;
        endcase
    end

    assign tw = twiddle(i_cmd.tw_idx);

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_WR_OR: begin op_a = 32'(r_wr); op_b = r_or; end
            MUL_WI_OI: begin op_a = 32'(r_wi); op_b = r_oi; end
            MUL_WR_OI: begin op_a = 32'(r_wr); op_b = r_oi; end
            MUL_WI_OR: begin op_a = 32'(r_wi); op_b = r_or; end
            MUL_RE_RE: begin op_a = r_er;      op_b = r_er; end
            default:   begin op_a = r_ei;      op_b = r_ei; end
        endcase
    end

    assign rsum = r_acc + 64'sd16384;
    assign rnd  = rsum >>> 15;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_e) begin
            r_er <= rdata[63:32];
            r_ei <= rdata[31:0];
        end
        if (i_cmd.ld_o) begin
            r_or <= rdata[63:32];
            r_oi <= rdata[31:0];
        end
        if (i_cmd.ld_tw) begin
            r_wr <= tw.wr;
            r_wi <= tw.wi;
        end
        r_prod <= op_a * op_b;
        case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= r_prod;
            ACC_ADD:  r_acc <= r_acc + r_prod;
            ACC_SUB:  r_acc <= r_acc - r_prod;
            default:  r_acc <= r_acc;
        endcase
        if (i_cmd.ld_tr) begin
            r_tr <= rnd[31:0];
        end
        if (i_cmd.ld_ti) begin
            r_ti <= rnd[31:0];
        end
    end

    // digit-by-digit root, then restoring divide by twice the count
    assign rem_sh  = {r_rem[25:0], r_rad[49:48]};
    assign trial   = {1'b0, r_root, 2'b01};
    assign sq_bit  = (rem_sh >= trial);
    assign root_nx = {r_root[23:0], sq_bit};
    assign dr_sh   = {r_dr, r_num[25]};
    assign dv_bit  = (dr_sh >= {1'b0, r_den});
    assign quo_nx  = {r_num[24:0], dv_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mph  <= M_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_mph)
                M_IDLE: begin
                    if (i_cmd.mag_start) begin
                        r_mph <= M_SQRT;
                    end
                end
                M_SQRT: begin
                    if (r_cnt == 5'd24) begin
                        r_mph <= M_DIV;
                    end
                end
                M_DIV: begin
                    if (r_cnt == 5'd25) begin
                        r_mph  <= M_IDLE;
                        r_done <= 1'b1;
                    end
                end
                default: r_mph <= M_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_mph)
            M_IDLE: begin
                r_rad  <= {r_acc[47:0], 2'b00};
                r_rem  <= 28'd0;
                r_root <= 25'd0;
                r_cnt  <= 5'd0;
                r_den  <= {i_cmd.n_count, 1'b0};
            end
            M_SQRT: begin
                r_rem  <= sq_bit ? rem_sh - trial : rem_sh;
                r_root <= root_nx;
                r_rad  <= {r_rad[47:0], 2'b00};
                if (r_cnt == 5'd24) begin
                    r_cnt <= 5'd0;
                    r_num <= {1'b0, root_nx} + {18'd0, r_den[8:1]};
                    r_dr  <= 9'd0;
                end else begin
                    r_cnt <= r_cnt + 5'd1;
                end
            end
            default: begin
                r_dr  <= dv_bit ? 9'(dr_sh - {1'b0, r_den}) : dr_sh[8:0];
                r_num <= quo_nx;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd25) begin
                    r_mag <= (|quo_nx[25:16]) ? 16'hFFFF : quo_nx[15:0];
                end
            end
        endcase
    end

    assign o_mag_done  = r_done;
    assign o_magnitude = r_mag;

endmodule

@@ rtl/fft_magnitude_spectrum.sv @@
// ----------------------------------------------------------------------------
// fft_magnitude_spectrum
// radix-2 fft of one real frame, emitting p/2 scaled bin magnitudes
//
// channel  | handshake        | data
// ---------+------------------+-----------------------------------------
// input    | start / busy     | i_sample, i_frame_end
// result   | o_strobe         | o_magnitude, o_bin_index, o_bin_last
//
// a sample transfers while start is high and busy is low.
// after the closing sample come zero padding from N up to p points, reordering
// of swapped pairs, butterflies on the single shared multiplier, and a pass
// per bin through the root and divide unit.
// synchronous reset clears control only; the sample store is not cleared.
// o_strobe marks each result for one cycle, and a result cannot be held off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fft_magnitude_spectrum import fms_pkg::*; #(
    parameter int MAX_POINTS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_sample,
    input  logic        i_frame_end,
    output logic        o_strobe,
    output logic [15:0] o_magnitude,
    output logic [5:0]  o_bin_index,
    output logic        o_bin_last
);

    t_cmd cmd;
    logic mag_done;

    fms_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_frame_end (i_frame_end),
        .i_mag_done  (mag_done),
        .o_busy      (busy),
        .o_cmd       (cmd),
        .o_strobe    (o_strobe),
        .o_bin_index (o_bin_index),
        .o_bin_last  (o_bin_last)
    );

    fms_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_sample    (signed'(i_sample)),
        .o_mag_done  (mag_done),
        .o_magnitude (o_magnitude)
    );

endmodule

@@ rtl/fms_checker.sv @@
// ----------------------------------------------------------------------------
// fms_checker
// port-level checks on the spectrum block, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fft_magnitude_spectrum_assert.svh"

module fms_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_frame_end,
    input logic o_strobe,
    input logic o_bin_last
);

    `FMS_ASSERT_NEXT(a_strobe_gap, o_strobe, !o_strobe)
    `FMS_ASSERT_NEXT(a_mid_frame_idle, start && !busy && !i_frame_end, !busy)
    `FMS_ASSERT_SAME(a_bin_busy, o_strobe && !o_bin_last, busy)
    `FMS_ASSERT_SAME(a_last_idle, o_strobe && o_bin_last, !busy)

endmodule

bind fft_magnitude_spectrum fms_checker u_fms_checker (.*);
